/* src/link_feedback_stats_reward_assert.svh */
// ----------------------------------------------------------------------------
// link feedback stats reward assertion macros
// shared property forms for the block's checks
// ----------------------------------------------------------------------------
`ifndef LINK_FEEDBACK_STATS_REWARD_ASSERT_SVH
`define LINK_FEEDBACK_STATS_REWARD_ASSERT_SVH

// same-cycle implication
`define LFSR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LFSR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/lfsr_pkg.sv */
// ----------------------------------------------------------------------------
// lfsr_pkg
// constants, widths and the reward curve table of the feedback stats block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfsr_pkg;

	localparam int SNR_WINDOW_DEF = 30;
	localparam int ACK_WINDOW_DEF = 60;
	localparam int EFF_BITS_DEF   = 10;

	localparam int S2_W  = 37;
	localparam int X_W   = 46;
	localparam int DVD_W = 32;
	localparam int DVS_W = 18;
	localparam int CURVE_STEPS = 32;
	localparam int ROM_W = 12;

	localparam logic [10:0] EFF_FLOOR_RST   = 11'd51;
	localparam logic [11:0] FLOOR_REWARD_RST = 12'hE80;

	localparam logic [7:0] REG_EFF_FLOOR    = 8'd0;
	localparam logic [7:0] REG_FLOOR_REWARD = 8'd1;

	function automatic logic [ROM_W-1:0] curve_rom(input logic [5:0] idx);
		logic [ROM_W-1:0] v;
		case (idx)
			6'd5, 6'd6, 6'd7: v = 12'd1;
			6'd8:  v = 12'd2;
			6'd9:  v = 12'd3;
			6'd10: v = 12'd4;
			6'd11: v = 12'd6;
			6'd12: v = 12'd9;
			6'd13: v = 12'd12;
			6'd14: v = 12'd18;
			6'd15: v = 12'd26;
			6'd16: v = 12'd38;
			6'd17: v = 12'd55;
			6'd18: v = 12'd79;
			6'd19: v = 12'd113;
			6'd20: v = 12'd161;
			6'd21: v = 12'd228;
			6'd22: v = 12'd319;
			6'd23: v = 12'd439;
			6'd24: v = 12'd593;
			6'd25: v = 12'd780;
			6'd26: v = 12'd997;
			6'd27: v = 12'd1232;
			6'd28: v = 12'd1471;
			6'd29: v = 12'd1696;
			6'd30: v = 12'd1896;
			6'd31: v = 12'd2064;
			6'd32: v = 12'd2197;
			default: v = 12'd0;
		endcase
		return v;
	endfunction

endpackage

/* src/link_feedback_stats_reward.sv */
// ----------------------------------------------------------------------------
// link_feedback_stats_reward
// transmit feedback statistics: counters, snr window mean and deviation,
// ack ratio and rate reward
// ----------------------------------------------------------------------------
// One feedback request gives one result. With no rate selected the result is
// offered at the edge that takes the request. Otherwise the update state
// updates the windows, the walk state steps through the filled snr window
// memory through one read port, the ST_MULA, ST_MULB and ST_VAR states set up
// the variance, a 2-bit-per-cycle square root runs, up to four divides run on
// one shared 1-bit-per-cycle divider and the ST_REW state forms the reward.
// The block takes no request until the result is taken. Configuration writes
// are always accepted.
`timescale 1ns / 1ps
`include "link_feedback_stats_reward_assert.svh"

module link_feedback_stats_reward
	import lfsr_pkg::*;
#(
	parameter int SNR_WINDOW = SNR_WINDOW_DEF,
	parameter int ACK_WINDOW = ACK_WINDOW_DEF,
	parameter int EFF_BITS   = EFF_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [55:0]  s_axis_tdata,  // success, snr_db, selected_rate, best_rate, pad
	input  logic         s_axis_tuser,  // snr_valid
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [191:0] m_axis_tdata,  // reward, mean_snr, std_snr, ack share,
	                                    // success_count, failure_count,
	                                    // success_run, failure_run, pad
	output logic         m_axis_tuser,  // stats_updated
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [11:0]  cfg_data
);

	localparam int SF_W  = $clog2(SNR_WINDOW + 1);
	localparam int SH_W  = $clog2(SNR_WINDOW);
	localparam int AF_W  = $clog2(ACK_WINDOW + 1);
	localparam int AH_W  = $clog2(ACK_WINDOW);
	localparam int SUM_W = 17 + $clog2(SNR_WINDOW);
	localparam int EFF_W = EFF_BITS + 1;
	localparam int FB    = EFF_BITS - 5;
	localparam int IP_W  = ROM_W + FB + 1;
	localparam int DC_W  = $clog2(DVD_W);

	typedef enum logic [3:0] {
		ST_IDLE, ST_UPD, ST_WALK, ST_MULA, ST_MULB, ST_VAR, ST_SQRT, ST_DIV, ST_REW, ST_OUT
	} state_t;

	typedef enum logic [1:0] {JOB_MEAN, JOB_STD, JOB_RATIO, JOB_EFF} job_t;

	state_t state_q;
	job_t   job_q;

	logic [10:0] eff_floor_q;
	logic [11:0] floor_reward_q;

	logic               success_q;
	logic [15:0]        sel_q, best_q;
	logic signed [15:0] last_snr_q;

	logic signed [15:0] snr_mem [SNR_WINDOW];
	logic               ack_mem [ACK_WINDOW];
	logic signed [15:0] snr_rd_q;
	logic               ack_rd_q;
	logic [SH_W-1:0]    snr_raddr;

	logic [SF_W-1:0]         snr_fill_q, walk_q;
	logic [SH_W-1:0]         snr_head_q;
	logic signed [SUM_W-1:0] snr_sum_q;
	logic [AF_W-1:0]         ack_fill_q, ack_ones_q;
	logic [AH_W-1:0]         ack_head_q;

	logic [31:0] succ_q, fail_q, srun_q, frun_q;

	logic              v_s1, v_s2;
	logic [31:0]       sq_s2;
	logic [S2_W-1:0]   s2_q;
	logic [X_W-1:0]    prod_a_q, prod_b_q;
	logic [X_W-1:0]    x_q, res_q, bit_q;
	logic [X_W:0]      diff;
	logic [X_W-1:0]    sq_try;

	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DC_W-1:0]   div_cnt_q;
	logic [DVS_W:0]    div_sh;
	logic              div_ge;
	logic [DVD_W-1:0]  quot;
	logic [DVD_W-1:0]  ld_dvd;
	logic [DVS_W-1:0]  ld_dvs;
	job_t              ld_job;

	logic [SUM_W-1:0]   sum_mag;
	logic [2*SUM_W-1:0] sum_sq;
	logic [EFF_W-1:0]  eff_q;
	logic [5:0]        c_idx;
	logic [FB-1:0]     c_frac;
	logic [ROM_W-1:0]  c_lo, c_d;
	logic [IP_W-1:0]   c_ip;
	logic [ROM_W-1:0]  c_val;
	logic [12:0]       rew_val;

	logic signed [15:0] held_mean_q;
	logic [15:0]        held_std_q, held_ratio_q;
	logic [12:0]        held_reward_q;
	logic               updated_q, out_valid_q;
	logic [15:0]        in_snr, in_sel, in_best;
	logic               issue;

	assign in_snr  = s_axis_tdata[16:1];
	assign in_sel  = s_axis_tdata[32:17];
	assign in_best = s_axis_tdata[48:33];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = updated_q;
	assign m_axis_tdata  = {3'b000, frun_q, srun_q, fail_q, succ_q, held_ratio_q, held_std_q,
		held_mean_q, held_reward_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_floor_q    <= EFF_FLOOR_RST;
			floor_reward_q <= FLOOR_REWARD_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_EFF_FLOOR:    eff_floor_q    <= cfg_data[10:0];
				REG_FLOOR_REWARD: floor_reward_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// window memories
	assign issue     = (state_q == ST_WALK) && (walk_q < snr_fill_q);
	assign snr_raddr = (state_q == ST_WALK) ? walk_q[SH_W-1:0] : snr_head_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_UPD) begin
			snr_mem[snr_head_q] <= last_snr_q;
			ack_mem[ack_head_q] <= success_q;
		end
		snr_rd_q <= snr_mem[snr_raddr];
		ack_rd_q <= ack_mem[ack_head_q];
	end

	// square root step
	assign diff   = {1'b0, prod_a_q} - {1'b0, prod_b_q};
	assign sq_try = res_q + bit_q;

	// divider step
	assign div_sh = {rem_q, dvd_q[DVD_W-1]};
	assign div_ge = div_sh >= {1'b0, dvs_q};
	assign quot   = {dvd_q[DVD_W-2:0], div_ge};

	assign sum_mag = snr_sum_q[SUM_W-1] ? SUM_W'(-snr_sum_q) : SUM_W'(snr_sum_q);
	assign sum_sq  = sum_mag * sum_mag;

	// next divide job
	always_comb begin
		ld_job = JOB_MEAN;
		ld_dvd = '0;
		ld_dvs = '0;
		case (state_q)
			ST_SQRT: begin
				ld_job = JOB_MEAN;
				ld_dvd = DVD_W'({sum_mag, 1'b0}) + DVD_W'(snr_fill_q);
				ld_dvs = DVS_W'({snr_fill_q, 1'b0});
			end
			default: begin
				case (job_q)
					JOB_MEAN: begin
						ld_job = JOB_STD;
						ld_dvd = DVD_W'(res_q) + DVD_W'(snr_fill_q);
						ld_dvs = DVS_W'({snr_fill_q, 1'b0});
					end
					default: begin
						ld_job = (job_q == JOB_STD) ? JOB_RATIO : JOB_EFF;
						if (job_q == JOB_STD) begin
							ld_dvd = DVD_W'({ack_ones_q, 16'h0000}) + DVD_W'(ack_fill_q);
							ld_dvs = DVS_W'({ack_fill_q, 1'b0});
						end else if (best_q > sel_q) begin
							ld_dvd = DVD_W'({sel_q, {(EFF_BITS + 1){1'b0}}}) + DVD_W'(best_q);
							ld_dvs = DVS_W'({best_q, 1'b0});
						end else begin
							ld_dvd = DVD_W'({sel_q, {(EFF_BITS + 1){1'b0}}}) + DVD_W'(sel_q);
							ld_dvs = DVS_W'({sel_q, 1'b0});
						end
					end
				endcase
			end
		endcase
	end

	// reward curve
	always_comb begin
		c_idx  = 6'(eff_q >> FB);
		c_frac = eff_q[FB-1:0];
		c_lo   = curve_rom(c_idx);
		c_d    = curve_rom(c_idx + 6'd1) - c_lo;
		c_ip   = IP_W'(c_d) * IP_W'(c_frac) + IP_W'(1 << (FB - 1));
		if (c_idx >= 6'(CURVE_STEPS)) begin
			c_val = curve_rom(6'(CURVE_STEPS));
		end else begin
			c_val = c_lo + ROM_W'(c_ip >> FB);
		end
		if (16'(eff_q) < 16'(eff_floor_q)) begin
			rew_val = {floor_reward_q[11], floor_reward_q};
		end else begin
			rew_val = 13'(c_val);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			job_q         <= JOB_MEAN;
			last_snr_q    <= '0;
			snr_fill_q    <= '0;
			snr_head_q    <= '0;
			snr_sum_q     <= '0;
			ack_fill_q    <= '0;
			ack_head_q    <= '0;
			ack_ones_q    <= '0;
			succ_q        <= '0;
			fail_q        <= '0;
			srun_q        <= '0;
			frun_q        <= '0;
			held_mean_q   <= '0;
			held_std_q    <= '0;
			held_ratio_q  <= '0;
			held_reward_q <= '0;
			updated_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			walk_q        <= '0;
			div_cnt_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						success_q <= s_axis_tdata[0];
						sel_q     <= in_sel;
						best_q    <= in_best;
						if (s_axis_tuser) begin
							last_snr_q <= in_snr;
						end
						if (in_sel == 16'h0000) begin
							updated_q   <= 1'b0;
							out_valid_q <= 1'b1;
							state_q     <= ST_OUT;
						end else begin
							if (s_axis_tdata[0]) begin
								succ_q <= (succ_q == '1) ? succ_q : succ_q + 32'd1;
								srun_q <= (srun_q == '1) ? srun_q : srun_q + 32'd1;
								frun_q <= '0;
							end else begin
								fail_q <= (fail_q == '1) ? fail_q : fail_q + 32'd1;
								frun_q <= (frun_q == '1) ? frun_q : frun_q + 32'd1;
								srun_q <= '0;
							end
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					if (snr_fill_q == SF_W'(SNR_WINDOW)) begin
						snr_sum_q <= snr_sum_q - SUM_W'(snr_rd_q) + SUM_W'(last_snr_q);
					end else begin
						snr_sum_q  <= snr_sum_q + SUM_W'(last_snr_q);
						snr_fill_q <= snr_fill_q + SF_W'(1);
					end
					snr_head_q <= (snr_head_q == SH_W'(SNR_WINDOW - 1)) ? '0 :
						snr_head_q + SH_W'(1);
					if (ack_fill_q == AF_W'(ACK_WINDOW)) begin
						ack_ones_q <= ack_ones_q - AF_W'(ack_rd_q) + AF_W'(success_q);
					end else begin
						ack_ones_q <= ack_ones_q + AF_W'(success_q);
						ack_fill_q <= ack_fill_q + AF_W'(1);
					end
					ack_head_q <= (ack_head_q == AH_W'(ACK_WINDOW - 1)) ? '0 :
						ack_head_q + AH_W'(1);
					walk_q  <= '0;
					s2_q    <= '0;
					v_s1    <= 1'b0;
					v_s2    <= 1'b0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					v_s1 <= issue;
					v_s2 <= v_s1;
					if (issue) begin
						walk_q <= walk_q + SF_W'(1);
					end
					sq_s2 <= 32'(snr_rd_q) * 32'(snr_rd_q);
					if (v_s2) begin
						s2_q <= s2_q + S2_W'(sq_s2);
					end
					if (!issue && !v_s1 && !v_s2) begin
						state_q <= ST_MULA;
					end
				end
				ST_MULA: begin
					prod_a_q <= X_W'(s2_q) * X_W'(snr_fill_q);
					state_q  <= ST_MULB;
				end
				ST_MULB: begin
					prod_b_q <= X_W'(sum_sq);
					state_q  <= ST_VAR;
				end
				ST_VAR: begin
					x_q     <= diff[X_W] ? '0 : {diff[X_W-3:0], 2'b00};
					res_q   <= '0;
					bit_q   <= X_W'(1) << (X_W - 2);
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (x_q >= sq_try) begin
						x_q   <= x_q - sq_try;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						job_q     <= ld_job;
						dvd_q     <= ld_dvd;
						dvs_q     <= ld_dvs;
						rem_q     <= '0;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q     <= div_ge ? DVS_W'(div_sh - {1'b0, dvs_q}) : div_sh[DVS_W-1:0];
					dvd_q     <= quot;
					div_cnt_q <= div_cnt_q + DC_W'(1);
					if (div_cnt_q == DC_W'(DVD_W - 1)) begin
						case (job_q)
							JOB_MEAN: held_mean_q <= snr_sum_q[SUM_W-1] ? 16'(-quot) : 16'(quot);
							JOB_STD: held_std_q <= quot[15:0];
							JOB_RATIO: held_ratio_q <= quot[15:0];
							default: eff_q <= quot[EFF_W-1:0];
						endcase
						if (job_q == JOB_EFF || (job_q == JOB_RATIO && !success_q)) begin
							if (job_q == JOB_RATIO) begin
								eff_q <= '0;
							end
							state_q <= ST_REW;
						end else begin
							job_q     <= ld_job;
							dvd_q     <= ld_dvd;
							dvs_q     <= ld_dvs;
							rem_q     <= '0;
							div_cnt_q <= '0;
						end
					end
				end
				ST_REW: begin
					held_reward_q <= rew_val;
					updated_q     <= 1'b1;
					out_valid_q   <= 1'b1;
					state_q       <= ST_OUT;
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LFSR_ASSERT_IMP(a_ready_no_out, s_axis_tready, !m_axis_tvalid, "request taken while result pending")
	`LFSR_ASSERT_IMP(a_snr_fill, 1'b1, snr_fill_q <= SF_W'(SNR_WINDOW), "snr fill beyond window")
	`LFSR_ASSERT_IMP(a_ack_ones, 1'b1, ack_ones_q <= ack_fill_q, "ack ones beyond fill")
	`LFSR_ASSERT_NXT(a_no_rate, s_axis_tvalid && s_axis_tready && in_sel == 16'h0000, m_axis_tvalid && !m_axis_tuser, "no-rate request not answered at once")

endmodule
